[sv/rvgi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvgi_pkg
// Shared types, constants and helpers for the vertical grid-line ray walker.
// ----------------------------------------------------------------------------
package rvgi_pkg;

  // Map geometry
  localparam int MAP_ROWS_MAX = 32;
  localparam int MAP_COLS_MAX = 32;
  localparam int ROW_W        = $clog2(MAP_ROWS_MAX);
  localparam int COL_W        = $clog2(MAP_COLS_MAX);
  localparam int MAP_DEPTH    = MAP_ROWS_MAX * MAP_COLS_MAX;
  localparam int ADDR_W       = ROW_W + COL_W;
  localparam int CELL_W       = 2;

  // Fixed point: tile is 32 pixels, 8 fraction bits, so 2^13 LSBs a tile
  localparam int FRAC_BITS    = 8;
  localparam int TILE_SHIFT   = 5 + FRAC_BITS;
  localparam int POS_W        = 18;
  localparam int TAN_W        = 24;
  localparam int TAN_FRAC     = 16;
  localparam int COORD_W      = 20;   // saturating internal coordinate
  localparam int ROWCNT_W     = 6;
  localparam int TAG_W        = 10;

  // Commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  // Cell kinds
  localparam logic [CELL_W-1:0] CELL_OPEN = 2'd0;
  localparam logic [CELL_W-1:0] CELL_WALL = 2'd1;
  localparam logic [CELL_W-1:0] CELL_VOID = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_WALL     = 2'd0,
    ST_LEFT_MAP = 2'd1,
    ST_NONPOS   = 2'd2
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    clear;     // clearing sweep, one map entry
    logic    wr_cell;   // write one cell from the input ports
    logic    load;      // capture a cast item
    logic    mul;       // first-line x and offset product
    logic    init;      // first y and y step
    logic    step;      // record probe point and advance one column
    logic    finish;    // produce the result
    status_e fin_status;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic nonpos;       // x or y at or below zero
    logic outside;      // beyond coordinate range or row count
    logic cell_wall;
    logic cell_open;
  } dp_stat_t;

  // Clamp a 24-bit signed sum to the internal coordinate range
  function automatic coord_t sat_coord(input logic signed [23:0] v);
    coord_t r;
    if (v > 24'sd524287) begin
      r = 20'sd524287;
    end else if (v < -24'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

[sv/rvgi_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvgi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rvgi_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[sv/rvgi_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvgi_ctrl
// Sequencer: clearing sweep, item intake, set-up and the column walk.
// ----------------------------------------------------------------------------
module rvgi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               command,
  input  rvgi_pkg::dp_stat_t stat,
  output rvgi_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MUL   = 6'b000100,
    S_INIT  = 6'b001000,
    S_PROBE = 6'b010000,
    S_LOOK  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   look;

  assign look = (state == S_LOOK);
  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.fin_status = rvgi_pkg::ST_WALL;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (command == rvgi_pkg::CMD_CAST) begin
            cmd.load   = 1'b1;
            state_next = S_MUL;
          end else begin
            cmd.wr_cell = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_INIT;
      end
      S_INIT: begin
        cmd.init   = 1'b1;
        state_next = S_PROBE;
      end
      S_PROBE, S_LOOK: begin
        // cell of the previous probe first, then the current point
        priority if (look && stat.cell_wall) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = rvgi_pkg::ST_WALL;
          state_next     = S_IDLE;
        end else if (look && !stat.cell_open) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = rvgi_pkg::ST_LEFT_MAP;
          state_next     = S_IDLE;
        end else if (stat.nonpos) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = rvgi_pkg::ST_NONPOS;
          state_next     = S_IDLE;
        end else if (stat.outside) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = rvgi_pkg::ST_LEFT_MAP;
          state_next     = S_IDLE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_LOOK;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

endmodule

[sv/rvgi_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvgi_datapath
// Map store, row-count register, coordinate arithmetic and result registers.
// ----------------------------------------------------------------------------
module rvgi_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  rvgi_pkg::cmd_t                      cmd,
  output rvgi_pkg::dp_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [rvgi_pkg::ROWCNT_W-1:0]       cfg_data,
  input  logic [rvgi_pkg::TAG_W-1:0]          ray_index,
  input  logic [rvgi_pkg::POS_W-1:0]          pos_x,
  input  logic [rvgi_pkg::POS_W-1:0]          pos_y,
  input  logic signed [rvgi_pkg::TAN_W-1:0]   tan_angle,
  input  logic                                facing_left,
  input  logic                                facing_up,
  input  logic [rvgi_pkg::ROW_W-1:0]          cell_row,
  input  logic [rvgi_pkg::COL_W-1:0]          cell_col,
  input  logic [rvgi_pkg::CELL_W-1:0]         cell_kind,
  output logic [rvgi_pkg::TAG_W-1:0]          ray_tag,
  output logic [1:0]                          status,
  output logic [rvgi_pkg::POS_W-1:0]          hit_x,
  output logic [rvgi_pkg::POS_W-1:0]          hit_y
);

  localparam int PROD_W = 15 + rvgi_pkg::TAN_W;   // offset x tangent
  localparam int STEP_W = rvgi_pkg::TAN_W + rvgi_pkg::TILE_SHIFT + 1;

  // Row-count register
  logic [rvgi_pkg::ROWCNT_W-1:0] map_row_count;
  logic [rvgi_pkg::ROWCNT_W-1:0] rows_eff;

  // Captured cast item
  logic [rvgi_pkg::TAG_W-1:0]        tag;
  logic [rvgi_pkg::POS_W-1:0]        px;
  logic [rvgi_pkg::POS_W-1:0]        py;
  logic signed [rvgi_pkg::TAN_W-1:0] tanv;
  logic                              left;
  logic                              up;

  // Walk state
  logic signed [PROD_W-1:0] prod;
  rvgi_pkg::coord_t          x;
  rvgi_pkg::coord_t          y;
  logic signed [20:0]        sy;
  logic [rvgi_pkg::POS_W-1:0] hx;
  logic [rvgi_pkg::POS_W-1:0] hy;

  // Clearing sweep
  logic [rvgi_pkg::ADDR_W-1:0] clr_cnt;

  // Map store ports
  logic                        ram_we;
  logic [rvgi_pkg::ADDR_W-1:0] ram_waddr;
  logic [rvgi_pkg::CELL_W-1:0] ram_wdata;
  logic [rvgi_pkg::ADDR_W-1:0] ram_raddr;
  logic [rvgi_pkg::CELL_W-1:0] ram_rdata;

  // Set-up arithmetic
  logic [rvgi_pkg::POS_W:0]         x0;
  logic signed [19:0]               dx_wide;
  logic signed [14:0]               dx;
  logic signed [PROD_W-1:0]         prod_rnd;
  logic signed [22:0]               y_off;
  rvgi_pkg::coord_t                 y0;
  logic signed [STEP_W-1:0]         tan_sh;
  logic signed [STEP_W-1:0]         sxtan;
  logic signed [STEP_W-1:0]         sxtan_rnd;
  rvgi_pkg::coord_t                 sy_sat;
  logic signed [20:0]               sy_fix;

  // Walk arithmetic
  logic signed [20:0]               sx;
  logic signed [rvgi_pkg::COORD_W-1:0] tx;
  rvgi_pkg::coord_t                 x_next;
  rvgi_pkg::coord_t                 y_next;

  // Row-count register, clamped on use
  always_ff @(posedge clk) begin
    if (rst) begin
      map_row_count <= 6'd32;
    end else if (cfg_we) begin
      map_row_count <= cfg_data;
    end
  end

  assign rows_eff = (map_row_count > rvgi_pkg::ROWCNT_W'(rvgi_pkg::MAP_ROWS_MAX))
                  ? rvgi_pkg::ROWCNT_W'(rvgi_pkg::MAP_ROWS_MAX) : map_row_count;

  // Clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Map store
  assign ram_we    = cmd.clear | cmd.wr_cell;
  assign ram_waddr = cmd.clear ? clr_cnt : {cell_row, cell_col};
  assign ram_wdata = cmd.clear ? rvgi_pkg::CELL_VOID : cell_kind;
  assign tx        = x - rvgi_pkg::COORD_W'(left);
  assign ram_raddr = {y[rvgi_pkg::TILE_SHIFT +: rvgi_pkg::ROW_W],
                      tx[rvgi_pkg::TILE_SHIFT +: rvgi_pkg::COL_W]};

  rvgi_ram #(
    .WIDTH (rvgi_pkg::CELL_W),
    .DEPTH (rvgi_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // First vertical line and offset to it
  assign x0 = {1'b0, px[rvgi_pkg::POS_W-1:rvgi_pkg::TILE_SHIFT],
               rvgi_pkg::TILE_SHIFT'(0)}
            + (left ? 19'd0 : 19'(1 << rvgi_pkg::TILE_SHIFT));
  assign dx_wide = $signed({1'b0, x0}) - $signed({2'b00, px});
  assign dx      = dx_wide[14:0];

  // First y: py + round(offset * tan)
  assign prod_rnd = prod + PROD_W'(1 << (rvgi_pkg::TAN_FRAC - 1));
  assign y_off    = prod_rnd[PROD_W-1:rvgi_pkg::TAN_FRAC];
  assign y0       = rvgi_pkg::sat_coord($signed({6'd0, py}) + 24'(y_off));

  // Y step: round(sx * tan), then forced to the vertical facing
  assign tan_sh    = {tanv[rvgi_pkg::TAN_W-1], tanv, rvgi_pkg::TILE_SHIFT'(0)};
  assign sxtan     = left ? -tan_sh : tan_sh;
  assign sxtan_rnd = sxtan + STEP_W'(1 << (rvgi_pkg::TAN_FRAC - 1));
  assign sy_sat    = rvgi_pkg::sat_coord(
                       24'($signed(sxtan_rnd[STEP_W-1:rvgi_pkg::TAN_FRAC])));
  always_comb begin
    if ((up && sy_sat > 0) || (!up && sy_sat < 0)) begin
      sy_fix = -21'(sy_sat);
    end else begin
      sy_fix = 21'(sy_sat);
    end
  end

  // Column step
  assign sx     = left ? -21'sd8192 : 21'sd8192;
  assign x_next = rvgi_pkg::sat_coord(24'(x) + 24'(sx));
  assign y_next = rvgi_pkg::sat_coord(24'(y) + 24'(sy));

  // Status flags: sweep end, checks on the current point, cell read last
  assign stat.clear_last = (clr_cnt == '1);
  assign stat.nonpos     = (x <= 0) || (y <= 0);
  assign stat.outside    = (x > 20'sd262143) || (y > 20'sd262143) ||
                           ({1'b0, y[rvgi_pkg::TILE_SHIFT +: rvgi_pkg::ROW_W]} >= rows_eff);
  assign stat.cell_wall  = (ram_rdata == rvgi_pkg::CELL_WALL);
  assign stat.cell_open  = (ram_rdata == rvgi_pkg::CELL_OPEN);

  // Cast capture and walk registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag  <= ray_index;
      px   <= pos_x;
      py   <= pos_y;
      tanv <= tan_angle;
      left <= facing_left;
      up   <= facing_up;
    end
    if (cmd.mul) begin
      prod <= dx * tanv;
      x    <= {1'b0, x0};
    end
    if (cmd.init) begin
      y  <= y0;
      sy <= sy_fix;
    end
    if (cmd.step) begin
      hx <= x[rvgi_pkg::POS_W-1:0];
      hy <= y[rvgi_pkg::POS_W-1:0];
      x  <= x_next;
      y  <= y_next;
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ray_tag <= tag;
      status  <= cmd.fin_status;
      if (cmd.fin_status == rvgi_pkg::ST_WALL) begin
        hit_x <= hx;
        hit_y <= hy;
      end else begin
        hit_x <= '0;
        hit_y <= '0;
      end
    end
  end

endmodule

[sv/ray_vertical_grid_intersection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_vertical_grid_intersection
// Walks a ray on vertical grid lines of a 32x32 map until a wall or an exit.
// ----------------------------------------------------------------------------
// Use:
//   An item is taken when start is high and busy is low. command 0 writes
//   one map cell in that cycle and gives no result; busy stays low.
//   command 1 casts a ray: busy rises for the walk and one result appears
//   on ray_tag/status/hit_x/hit_y with done high for exactly one cycle.
//   The receiver cannot stall; a result must be taken on its strobe.
// Walk:
//   A cast passes a multiply state and a rounding state for set-up, then
//   reads map columns one after another until it stops. The registered map
//   read of one column overlaps the coordinate step to the next. A new item
//   may be taken in the cycle the strobe is shown.
// Reset:
//   rst (synchronous) clears control and sets map_row_count to 32. The map
//   is then swept to void, one entry a cycle, over all 1024 entries with busy
//   high; cfg_we writes are still taken during the sweep.
// ----------------------------------------------------------------------------
module ray_vertical_grid_intersection (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [rvgi_pkg::TAG_W-1:0]        ray_index,
  input  logic [rvgi_pkg::POS_W-1:0]        pos_x,
  input  logic [rvgi_pkg::POS_W-1:0]        pos_y,
  input  logic signed [rvgi_pkg::TAN_W-1:0] tan_angle,
  input  logic                              facing_left,
  input  logic                              facing_up,
  input  logic [rvgi_pkg::ROW_W-1:0]        cell_row,
  input  logic [rvgi_pkg::COL_W-1:0]        cell_col,
  input  logic [rvgi_pkg::CELL_W-1:0]       cell_kind,
  input  logic                              cfg_we,
  input  logic [rvgi_pkg::ROWCNT_W-1:0]     cfg_data,
  output logic                              done,
  output logic [rvgi_pkg::TAG_W-1:0]        ray_tag,
  output logic [1:0]                        status,
  output logic [rvgi_pkg::POS_W-1:0]        hit_x,
  output logic [rvgi_pkg::POS_W-1:0]        hit_y
);

  rvgi_pkg::cmd_t     cmd;
  rvgi_pkg::dp_stat_t stat;

  // Sequencer
  rvgi_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  // Datapath and map store
  rvgi_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .ray_index   (ray_index),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .tan_angle   (tan_angle),
    .facing_left (facing_left),
    .facing_up   (facing_up),
    .cell_row    (cell_row),
    .cell_col    (cell_col),
    .cell_kind   (cell_kind),
    .ray_tag     (ray_tag),
    .status      (status),
    .hit_x       (hit_x),
    .hit_y       (hit_y)
  );

endmodule

[sv/rvgi_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvgi_checker
// Port-level checks of the ray walker, bound to the top level.
// ----------------------------------------------------------------------------
module rvgi_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         command,
  input logic                         done,
  input logic [1:0]                   status,
  input logic [rvgi_pkg::POS_W-1:0]   hit_x,
  input logic [rvgi_pkg::POS_W-1:0]   hit_y
);

  // A cast transfer starts a walk
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == rvgi_pkg::CMD_CAST) |=> busy)
    else $error("cast transfer did not raise busy");

  // The block is ready again when its result is shown
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // A result strobe lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held over two cycles");

  // Only defined status codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == rvgi_pkg::ST_WALL || status == rvgi_pkg::ST_LEFT_MAP ||
              status == rvgi_pkg::ST_NONPOS))
    else $error("undefined status code");

  // No wall, no coordinates
  a_zero_hit: assert property (@(posedge clk) disable iff (rst)
    (done && status != rvgi_pkg::ST_WALL) |-> (hit_x == '0 && hit_y == '0))
    else $error("hit coordinates without a wall hit");

endmodule

bind ray_vertical_grid_intersection rvgi_checker u_rvgi_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .command (command),
  .done    (done),
  .status  (status),
  .hit_x   (hit_x),
  .hit_y   (hit_y)
);
